// ===== src/msr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package msr_pkg;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_NOROOT = 2'd1;
  localparam logic [1:0] ST_CAP    = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DIVW, S_NZ, S_POW_CHK, S_POW_W1, S_POW_W2, S_EULER,
    S_SHORT, S_QSPLIT, S_ZSTART, S_ZCHK, S_SETC, S_POWT, S_SETT, S_POWR,
    S_SETR, S_LOOP, S_ORDW, S_ORDCHK, S_BSQ, S_BSQW, S_CW, S_TW, S_RW, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIV, OP_MUL, OP_POW, OP_PE_SHIFT, OP_Q_SHIFT,
    OP_Z_INC, OP_SET_C, OP_SET_T, OP_SET_R, OP_B_FROM_C, OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    MK_PR_PB, MK_PB_PB, MK_TT, MK_TMPSQ, MK_BSQ, MK_C_BB, MK_T_TC, MK_R_RB
  } mk_t;

  typedef enum logic {BS_N, BS_Z} bsel_t;

  typedef enum logic [1:0] {ES_HALF, ES_P4, ES_Q, ES_QH} esel_t;

  typedef enum logic [1:0] {RS_ZERO, RS_NBIT, RS_PR, RS_R} rsel_t;

  typedef struct packed {
    op_t        op;
    mk_t        mk;
    bsel_t      bsel;
    esel_t      esel;
    rsel_t      rsel;
    logic [1:0] fst;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic pe_zero;
    logic pe_odd;
    logic pr_one;
    logic pr_pm1;
    logic t_one;
    logic tmp_one;
    logic p_zero;
    logic p_one;
    logic p_two;
    logic n_zero;
    logic p_mod4_3;
    logic q_even_nz;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/msr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msr_dp #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire msr_pkg::cmd_t         cmd,
  input  wire logic [DATA_WIDTH-1:0] in_value,
  input  wire logic [DATA_WIDTH-1:0] in_modulus,
  output msr_pkg::sts_t              sts,
  output logic [DATA_WIDTH-1:0]      out_root,
  output logic [1:0]                 out_status
);
  import msr_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);

  logic [W-1:0] p_r, n_r, half_r, q_r, z_r, c_r, t_r, rr_r, b_r, tmp_r;
  logic [W-1:0] pr_r, pb_r, pe_r, rem_r, dq_r, ma_r, mb_r, acc_r;
  logic [W-1:0] root_r;
  logic [1:0]   status_r;
  mk_t          mk_r;
  logic [CW-1:0] cnt_r;
  logic         ph_r, mul_busy_r, div_busy_r;

  logic [W-1:0] opa, opb, dbl, addv, rem_nxt, base_sel, exp_sel, root_sel;
  logic [W:0]   trial;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  always_comb begin
    case (cmd.mk)
      MK_PR_PB: begin opa = pr_r;  opb = pb_r;  end
      MK_PB_PB: begin opa = pb_r;  opb = pb_r;  end
      MK_TT:    begin opa = t_r;   opb = t_r;   end
      MK_TMPSQ: begin opa = tmp_r; opb = tmp_r; end
      MK_BSQ:   begin opa = b_r;   opb = b_r;   end
      MK_C_BB:  begin opa = b_r;   opb = b_r;   end
      MK_T_TC:  begin opa = t_r;   opb = c_r;   end
      MK_R_RB:  begin opa = rr_r;  opb = b_r;   end
      default:  begin opa = t_r;   opb = t_r;   end
    endcase
  end

  always_comb begin
    base_sel = (cmd.bsel == BS_Z) ? z_r : n_r;
    case (cmd.esel)
      ES_HALF: exp_sel = half_r;
      ES_P4:   exp_sel = (p_r >> 2) + W'(1);
      ES_Q:    exp_sel = q_r;
      ES_QH:   exp_sel = (q_r >> 1) + W'(1);
      default: exp_sel = half_r;
    endcase
    case (cmd.rsel)
      RS_NBIT: root_sel = W'(n_r[0]);
      RS_PR:   root_sel = pr_r;
      RS_R:    root_sel = rr_r;
      default: root_sel = '0;
    endcase
  end

  assign dbl   = add_mod(acc_r, acc_r, p_r);
  assign addv  = mb_r[W-1] ? add_mod(acc_r, ma_r, p_r) : acc_r;
  assign trial = {rem_r, dq_r[W-1]};
  assign rem_nxt = (trial >= {1'b0, p_r}) ? W'(trial - {1'b0, p_r}) : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      div_busy_r <= 1'b0;
      status_r   <= ST_FOUND;
    end else begin
      if (cmd.op == OP_MUL) mul_busy_r <= 1'b1;
      else if (mul_busy_r && ph_r && cnt_r == '0) mul_busy_r <= 1'b0;
      if (cmd.op == OP_DIV) div_busy_r <= 1'b1;
      else if (div_busy_r && cnt_r == '0) div_busy_r <= 1'b0;
      if (cmd.op == OP_FINISH) status_r <= cmd.fst;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        p_r    <= in_modulus;
        n_r    <= in_value;
        q_r    <= in_modulus - W'(1);
        half_r <= (in_modulus - W'(1)) >> 1;
        z_r    <= W'(2);
      end
      OP_DIV: begin
        rem_r <= '0;
        dq_r  <= n_r;
        cnt_r <= CW'(W - 1);
      end
      OP_MUL: begin
        ma_r  <= opa;
        mb_r  <= opb;
        acc_r <= '0;
        cnt_r <= CW'(W - 1);
        ph_r  <= 1'b0;
        mk_r  <= cmd.mk;
      end
      OP_POW: begin
        pr_r <= W'(1);
        pb_r <= base_sel;
        pe_r <= exp_sel;
      end
      OP_PE_SHIFT: pe_r   <= pe_r >> 1;
      OP_Q_SHIFT:  q_r    <= q_r >> 1;
      OP_Z_INC:    z_r    <= (z_r + W'(1) == p_r) ? '0 : z_r + W'(1);
      OP_SET_C:    c_r    <= pr_r;
      OP_SET_T:    t_r    <= pr_r;
      OP_SET_R:    rr_r   <= pr_r;
      OP_B_FROM_C: b_r    <= c_r;
      OP_FINISH:   root_r <= root_sel;
      default: begin
        if (div_busy_r) begin
          rem_r <= rem_nxt;
          dq_r  <= dq_r << 1;
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) n_r <= rem_nxt;
        end else if (mul_busy_r) begin
          ph_r <= ~ph_r;
          if (!ph_r) begin
            acc_r <= dbl;
          end else begin
            acc_r <= addv;
            mb_r  <= mb_r << 1;
            cnt_r <= cnt_r - CW'(1);
            if (cnt_r == '0) begin
              case (mk_r)
                MK_PR_PB: pr_r  <= addv;
                MK_PB_PB: pb_r  <= addv;
                MK_TT:    tmp_r <= addv;
                MK_TMPSQ: tmp_r <= addv;
                MK_BSQ:   b_r   <= addv;
                MK_C_BB:  c_r   <= addv;
                MK_T_TC:  t_r   <= addv;
                MK_R_RB:  rr_r  <= addv;
                default:  tmp_r <= addv;
              endcase
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    sts.mul_busy  = mul_busy_r;
    sts.div_busy  = div_busy_r;
    sts.pe_zero   = (pe_r == '0);
    sts.pe_odd    = pe_r[0];
    sts.pr_one    = (pr_r == W'(1));
    sts.pr_pm1    = (pr_r == p_r - W'(1));
    sts.t_one     = (t_r == W'(1));
    sts.tmp_one   = (tmp_r == W'(1));
    sts.p_zero    = (p_r == '0);
    sts.p_one     = (p_r == W'(1));
    sts.p_two     = (p_r == W'(2));
    sts.n_zero    = (n_r == '0);
    sts.p_mod4_3  = (p_r[1:0] == 2'b11);
    sts.q_even_nz = (q_r != '0) && !q_r[0];
  end

  assign out_root   = root_r;
  assign out_status = status_r;

endmodule
`default_nettype wire

// ===== src/msr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msr_ctrl #(
  parameter int DATA_WIDTH       = 64,
  parameter int MAX_SEARCH_STEPS = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire msr_pkg::sts_t  sts,
  output msr_pkg::cmd_t       cmd
);
  import msr_pkg::*;

  localparam int SW = $clog2(DATA_WIDTH) + 1;
  localparam int TW = $clog2(MAX_SEARCH_STEPS + 1);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [SW-1:0] s_r, s_nxt, m_r, m_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [TW-1:0] tries_r, tries_nxt;
  logic [1:0]    fst_r, fst_nxt;
  rsel_t         rsel_r, rsel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          cap_i, cap_tries, j_more, out_free;

  assign cap_i     = (i_r >= m_r) || (32'(i_r) >= 32'(MAX_SEARCH_STEPS));
  assign cap_tries = (32'(tries_r) + 32'd1) >= 32'(MAX_SEARCH_STEPS);
  assign j_more    = ({1'b0, j_r} + {1'b0, i_r} + (SW + 1)'(1)) < {1'b0, m_r};
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK:   state_nxt = (sts.p_zero || sts.p_one || sts.p_two) ? S_FIN : S_DIVW;
      S_DIVW:    if (!sts.div_busy) state_nxt = S_NZ;
      S_NZ:      state_nxt = sts.n_zero ? S_FIN : S_POW_CHK;
      S_POW_CHK: begin
        if (sts.pe_zero) state_nxt = ret_r;
        else state_nxt = sts.pe_odd ? S_POW_W1 : S_POW_W2;
      end
      S_POW_W1:  if (!sts.mul_busy) state_nxt = S_POW_W2;
      S_POW_W2:  if (!sts.mul_busy) state_nxt = S_POW_CHK;
      S_EULER: begin
        if (!sts.pr_one) state_nxt = S_FIN;
        else state_nxt = sts.p_mod4_3 ? S_POW_CHK : S_QSPLIT;
      end
      S_SHORT:   state_nxt = S_FIN;
      S_QSPLIT:  if (!sts.q_even_nz) state_nxt = S_ZSTART;
      S_ZSTART:  state_nxt = S_POW_CHK;
      S_ZCHK: begin
        if (sts.pr_pm1) state_nxt = S_POW_CHK;
        else state_nxt = cap_tries ? S_FIN : S_ZSTART;
      end
      S_SETC:    state_nxt = S_POWT;
      S_POWT:    state_nxt = S_POW_CHK;
      S_SETT:    state_nxt = S_POWR;
      S_POWR:    state_nxt = S_POW_CHK;
      S_SETR:    state_nxt = S_LOOP;
      S_LOOP:    state_nxt = sts.t_one ? S_FIN : S_ORDW;
      S_ORDW:    if (!sts.mul_busy) state_nxt = S_ORDCHK;
      S_ORDCHK: begin
        if (cap_i) state_nxt = S_FIN;
        else state_nxt = sts.tmp_one ? S_BSQ : S_ORDW;
      end
      S_BSQ:     state_nxt = j_more ? S_BSQW : S_CW;
      S_BSQW:    if (!sts.mul_busy) state_nxt = S_BSQ;
      S_CW:      if (!sts.mul_busy) state_nxt = S_TW;
      S_TW:      if (!sts.mul_busy) state_nxt = S_RW;
      S_RW:      if (!sts.mul_busy) state_nxt = S_LOOP;
      S_FIN:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = OP_NONE;
    in_tready     = 1'b0;
    ret_nxt       = ret_r;
    s_nxt         = s_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    tries_nxt     = tries_r;
    fst_nxt       = fst_r;
    rsel_nxt      = rsel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = OP_LOAD;
          s_nxt  = '0;
        end
      end
      S_CHECK: begin
        if (sts.p_zero) begin
          fst_nxt = ST_NOROOT; rsel_nxt = RS_ZERO;
        end else if (sts.p_one) begin
          fst_nxt = ST_FOUND; rsel_nxt = RS_ZERO;
        end else if (sts.p_two) begin
          fst_nxt = ST_FOUND; rsel_nxt = RS_NBIT;
        end else begin
          cmd.op = OP_DIV;
        end
      end
      S_NZ: begin
        if (sts.n_zero) begin
          fst_nxt = ST_FOUND; rsel_nxt = RS_ZERO;
        end else begin
          cmd.op = OP_POW; cmd.bsel = BS_N; cmd.esel = ES_HALF; ret_nxt = S_EULER;
        end
      end
      S_POW_CHK: begin
        if (!sts.pe_zero) begin
          cmd.op = OP_MUL;
          cmd.mk = sts.pe_odd ? MK_PR_PB : MK_PB_PB;
        end
      end
      S_POW_W1: begin
        if (!sts.mul_busy) begin
          cmd.op = OP_MUL; cmd.mk = MK_PB_PB;
        end
      end
      S_POW_W2: if (!sts.mul_busy) cmd.op = OP_PE_SHIFT;
      S_EULER: begin
        if (!sts.pr_one) begin
          fst_nxt = ST_NOROOT; rsel_nxt = RS_ZERO;
        end else if (sts.p_mod4_3) begin
          cmd.op = OP_POW; cmd.bsel = BS_N; cmd.esel = ES_P4; ret_nxt = S_SHORT;
        end
      end
      S_SHORT: begin
        fst_nxt = ST_FOUND; rsel_nxt = RS_PR;
      end
      S_QSPLIT: begin
        if (sts.q_even_nz) begin
          cmd.op = OP_Q_SHIFT;
          s_nxt  = s_r + SW'(1);
        end else begin
          tries_nxt = '0;
        end
      end
      S_ZSTART: begin
        cmd.op = OP_POW; cmd.bsel = BS_Z; cmd.esel = ES_HALF; ret_nxt = S_ZCHK;
      end
      S_ZCHK: begin
        if (sts.pr_pm1) begin
          cmd.op = OP_POW; cmd.bsel = BS_Z; cmd.esel = ES_Q; ret_nxt = S_SETC;
        end else if (cap_tries) begin
          fst_nxt = ST_CAP; rsel_nxt = RS_ZERO;
        end else begin
          cmd.op    = OP_Z_INC;
          tries_nxt = tries_r + TW'(1);
        end
      end
      S_SETC: begin
        cmd.op = OP_SET_C;
        m_nxt  = s_r;
      end
      S_POWT: begin
        cmd.op = OP_POW; cmd.bsel = BS_N; cmd.esel = ES_Q; ret_nxt = S_SETT;
      end
      S_SETT: cmd.op = OP_SET_T;
      S_POWR: begin
        cmd.op = OP_POW; cmd.bsel = BS_N; cmd.esel = ES_QH; ret_nxt = S_SETR;
      end
      S_SETR: cmd.op = OP_SET_R;
      S_LOOP: begin
        if (sts.t_one) begin
          fst_nxt = ST_FOUND; rsel_nxt = RS_R;
        end else begin
          cmd.op = OP_MUL; cmd.mk = MK_TT;
          i_nxt  = SW'(1);
        end
      end
      S_ORDCHK: begin
        if (cap_i) begin
          fst_nxt = ST_CAP; rsel_nxt = RS_ZERO;
        end else if (sts.tmp_one) begin
          cmd.op = OP_B_FROM_C;
          j_nxt  = '0;
        end else begin
          cmd.op = OP_MUL; cmd.mk = MK_TMPSQ;
          i_nxt  = i_r + SW'(1);
        end
      end
      S_BSQ: begin
        cmd.op = OP_MUL;
        if (j_more) begin
          cmd.mk = MK_BSQ;
          j_nxt  = j_r + SW'(1);
        end else begin
          cmd.mk = MK_C_BB;
          m_nxt  = i_r;
        end
      end
      S_CW: begin
        if (!sts.mul_busy) begin
          cmd.op = OP_MUL; cmd.mk = MK_T_TC;
        end
      end
      S_TW: begin
        if (!sts.mul_busy) begin
          cmd.op = OP_MUL; cmd.mk = MK_R_RB;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op        = OP_FINISH;
          cmd.fst       = fst_r;
          cmd.rsel      = rsel_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    m_r     <= m_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    tries_r <= tries_nxt;
    fst_r   <= fst_nxt;
    rsel_r  <= rsel_nxt;
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== src/modular_square_root.sv =====
// Modular square root r with r*r = value mod p, one beat in, one beat out. The block
// works on one item at a time: modulus 0, 1, 2 end without any arithmetic, a zero
// residue ends after the reduction, and all other items run every exponentiation and
// squaring through one bit-serial modular multiplier that doubles, then adds, for each
// multiplier bit; a p = 3 mod 4 modulus costs two exponentiations, others add the
// non-residue search (up to MAX_SEARCH_STEPS exponentiations) and the order loop. status
// 0 means a root, 1 no root, 2 search cap reached; root is 0 unless status is 0. A
// finished result is held on the output while the next item is taken in.
`timescale 1ns / 1ps
`default_nettype none
module modular_square_root #(
  parameter int DATA_WIDTH       = 64,
  parameter int MAX_SEARCH_STEPS = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // value [63:0], modulus [127:64]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // root [63:0]
  output logic [1:0]        out_tuser   // status [1:0]
);
  import msr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [DATA_WIDTH-1:0] root;

  msr_ctrl #(
    .DATA_WIDTH       (DATA_WIDTH),
    .MAX_SEARCH_STEPS (MAX_SEARCH_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  msr_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   (in_tdata[DATA_WIDTH-1:0]),
    .in_modulus (in_tdata[64+DATA_WIDTH-1:64]),
    .sts        (sts),
    .out_root   (root),
    .out_status (out_tuser)
  );

  assign out_tdata = 64'(root);

`ifndef ASSERT_OFF
  a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_FOUND |-> out_tdata == 64'd0)
    else $error("nonzero root with failing status");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined status code");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while busy");
`endif

endmodule
`default_nettype wire

// ===== sim/modular_square_root_tb.sv =====
`timescale 1ns / 1ps
module modular_square_root_tb;
  import msr_pkg::*;

  localparam int SEARCH_CAP = 256;

  typedef struct {
    logic [63:0] root;
    logic [1:0]  status;
  } root_res_t;

  typedef struct {
    logic [63:0] value;
    logic [63:0] modulus;
    bit          typed;
    logic [63:0] root;
    logic [1:0]  status;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;  // value [63:0], modulus [127:64]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;      // root [63:0]
  logic [1:0]   out_tuser;      // status [1:0]

  root_res_t pending_roots[$];
  int        mismatches = 0;
  bit        stim_done = 1'b0;
  int        stall_len = 0;

  modular_square_root dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = (128'(a) % 128'(m)) * (128'(b) % 128'(m));
    return 64'(prod % 128'(m));
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    base = base % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, base, m);
      base = mulmod(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic root_res_t sqrt_mod_p(logic [63:0] n, logic [63:0] p);
    root_res_t   res;
    logic [63:0] half, q, z, c, t, r, b, tmp;
    int          s, m, i, tries;
    res.root = '0;
    res.status = ST_FOUND;
    if (p == 0) begin
      res.status = ST_NOROOT;
      return res;
    end
    if (p == 1) return res;
    if (p == 2) begin
      res.root = {63'd0, n[0]};
      return res;
    end
    n = n % p;
    if (n == 0) return res;
    half = (p - 1) >> 1;
    if (powmod(n, half, p) != 1) begin
      res.status = ST_NOROOT;
      return res;
    end
    if (p[1:0] == 2'b11) begin
      res.root = powmod(n, (p >> 2) + 1, p);
      return res;
    end
    q = p - 1;
    s = 0;
    while (q != 0 && !q[0]) begin
      q = q >> 1;
      s++;
    end
    z = 2;
    tries = 0;
    while (powmod(z, half, p) != p - 1) begin
      tries++;
      if (tries >= SEARCH_CAP) begin
        res.status = ST_CAP;
        return res;
      end
      z++;
    end
    m = s;
    c = powmod(z, q, p);
    t = powmod(n, q, p);
    r = powmod(n, (q >> 1) + 1, p);
    forever begin
      if (t == 1) begin
        res.root = r;
        return res;
      end
      i = 1;
      tmp = mulmod(t, t, p);
      while (tmp != 1) begin
        if (i >= m || i >= SEARCH_CAP) begin
          res.status = ST_CAP;
          return res;
        end
        tmp = mulmod(tmp, tmp, p);
        i++;
      end
      if (i >= m || i >= SEARCH_CAP) begin
        res.status = ST_CAP;
        return res;
      end
      b = c;
      for (int j = 0; j + i + 1 < m; j++) b = mulmod(b, b, p);
      m = i;
      c = mulmod(b, b, p);
      t = mulmod(t, c, p);
      r = mulmod(r, b, p);
    end
  endfunction

  task automatic send_beat(logic [63:0] value, logic [63:0] modulus, root_res_t want);
    int gap;
    if ($urandom_range(0, 9) < 7) begin
      gap = $urandom_range(0, 2);
    end else begin
      gap = $urandom_range(3, 40);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {modulus, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_roots.push_back(want);
  endtask

  always @(posedge clk) begin
    if (stall_len > 0) begin
      stall_len <= stall_len - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_len <= $urandom_range(10, 60);
      out_tready <= 1'b0;
    end else begin
      out_tready <= stim_done || ($urandom_range(0, 99) < 80);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: root=%h status=%0d", out_tdata, out_tuser);
      end else begin
        root_res_t want;
        want = pending_roots.pop_front();
        if (out_tdata !== want.root || out_tuser !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected root=%h status=%0d, got root=%h status=%0d",
                     want.root, want.status, out_tdata, out_tuser);
        end
      end
    end
  end

  initial begin
    #(64'd4_000_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t   rows[$];
    root_res_t   want;
    logic [63:0] primes[8];
    logic [63:0] val, modv, x;
    int          pick;

    primes = '{64'd18446744073709551557, 64'd2305843009213693951,
               64'd9223372036854775783, 64'd998244353, 64'd1000000007,
               64'd65537, 64'd97, 64'd17};

    rows.push_back('{64'd5, 64'd0, 1'b1, 64'd0, ST_NOROOT});
    rows.push_back('{'1, 64'd1, 1'b1, 64'd0, ST_FOUND});
    rows.push_back('{'1, 64'd2, 1'b1, 64'd1, ST_FOUND});
    rows.push_back('{64'd0, 64'd2, 1'b1, 64'd0, ST_FOUND});
    rows.push_back('{64'd0, 64'd7, 1'b1, 64'd0, ST_FOUND});
    rows.push_back('{64'd13, 64'd13, 1'b1, 64'd0, ST_FOUND});
    rows.push_back('{64'd3, 64'd7, 1'b1, 64'd0, ST_NOROOT});
    rows.push_back('{64'd1, 64'd9, 1'b1, 64'd0, ST_CAP});
    rows.push_back('{64'd2, 64'd7, 1'b0, 64'd0, ST_FOUND});
    rows.push_back('{64'd10, 64'd13, 1'b0, 64'd0, ST_FOUND});
    rows.push_back('{64'd4, 64'd17, 1'b0, 64'd0, ST_FOUND});
    rows.push_back('{'1, '1, 1'b0, 64'd0, ST_FOUND});
    rows.push_back('{'1, 64'd18446744073709551557, 1'b0, 64'd0, ST_FOUND});
    rows.push_back('{64'd4, 64'd18446744073709551557, 1'b0, 64'd0, ST_FOUND});
    rows.push_back('{64'd9, 64'd2305843009213693951, 1'b0, 64'd0, ST_FOUND});
    rows.push_back('{64'd3, 64'd998244353, 1'b0, 64'd0, ST_FOUND});
    rows.push_back('{64'd1, 64'd21, 1'b0, 64'd0, ST_FOUND});
    rows.push_back('{64'd4, 64'd8, 1'b0, 64'd0, ST_FOUND});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].typed) begin
        want.root = rows[k].root;
        want.status = rows[k].status;
      end else begin
        want = sqrt_mod_p(rows[k].value, rows[k].modulus);
      end
      send_beat(rows[k].value, rows[k].modulus, want);
    end

    repeat (100) begin
      pick = $urandom_range(0, 99);
      val = {$urandom(), $urandom()};
      if (pick < 60) begin
        modv = primes[$urandom_range(0, 7)];
        if ($urandom_range(0, 1)) begin
          x = {$urandom(), $urandom()};
          val = mulmod(x, x, modv) +
                ($urandom_range(0, 1) ? 64'(modv * 64'($urandom_range(0, 3))) : 64'd0);
        end
      end else if (pick < 80) begin
        modv = {$urandom(), $urandom()};
      end else if (pick < 92) begin
        modv = 64'($urandom_range(3, 63));
      end else begin
        modv = 64'($urandom_range(0, 3));
      end
      send_beat(val, modv, sqrt_mod_p(val, modv));
    end

    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
